[src/wrp_pkg.sv]
// Shared types and constants of the log ring pointer manager.
// Used by wrp_ctrl and by the wal_ring_pointer_manager top level; no dependencies.
package wrp_pkg;

    localparam int CAPACITY_LOG2 = 16;
    localparam int BLOCK_LOG2    = 12;
    localparam int IDX_W         = CAPACITY_LOG2 - BLOCK_LOG2;
    localparam int NUM_BLOCKS    = 1 << IDX_W;
    localparam int CNT_W         = IDX_W + 1;
    localparam int LAST_W        = 64 - BLOCK_LOG2;
    localparam int LEN_W         = 17;

    localparam logic [63:0]       RING_BYTES = 64'(1) << CAPACITY_LOG2;
    localparam logic [63:0]       RING_MASK  = RING_BYTES - 64'(1);
    localparam logic [63:0]       BLK_BYTES  = 64'(1) << BLOCK_LOG2;
    localparam logic [LEN_W-1:0]  LEN_MAX    = '1;
    localparam logic [IDX_W-1:0]  IDX_LAST   = '1;

    typedef enum logic [1:0] {
        OP_RESERVE = 2'd0,
        OP_COMMIT  = 2'd1,
        OP_PEEK    = 2'd2,
        OP_ADVANCE = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_NO_ROOM = 2'd1,
        STAT_EMPTY   = 2'd2
    } status_t;

    typedef struct packed {
        opcode_t          opcode;
        logic [63:0]      range_base;
        logic [LEN_W-1:0] byte_count;
    } in_item_t;

    typedef struct packed {
        status_t          status;
        logic [63:0]      position;
        logic [LEN_W-1:0] length;
        logic [63:0]      commit_position;
    } out_item_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic             wdata;
        logic [IDX_W-1:0] raddr;
    } ram_req_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_SPAN,
        S_MARK,
        S_WALK_RD,
        S_WALK_CHK,
        S_DONE
    } state_t;

endpackage

[src/wrp_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module wrp_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[src/wrp_ctrl.sv]
// Sequencer and head registers of the log ring pointer manager.
// Depends on wrp_pkg; drives the block flag RAM through a wrp_pkg::ram_req_t.
module wrp_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  wrp_pkg::in_item_t s_data,
    output logic              res_valid,
    input  logic              res_ready,
    output wrp_pkg::out_item_t res_data,
    output wrp_pkg::ram_req_t ram_req,
    input  logic              ram_rdata
);

    wrp_pkg::state_t                   state_reg, state_next;
    wrp_pkg::opcode_t                  op_reg, op_next;
    logic [63:0]                       off_reg, off_next;
    logic [wrp_pkg::LEN_W-1:0]         cnt_reg, cnt_next;
    logic [63:0]                       wr_pos_reg, wr_pos_next;
    logic [63:0]                       rd_pos_reg, rd_pos_next;
    logic [63:0]                       cm_pos_reg, cm_pos_next;
    logic [wrp_pkg::IDX_W-1:0]         idx_reg, idx_next;
    logic [wrp_pkg::CNT_W-1:0]         left_reg, left_next;
    logic [wrp_pkg::LAST_W-1:0]        last_reg, last_next;
    wrp_pkg::status_t                  status_reg, status_next;
    logic [63:0]                       pos_reg, pos_next;
    logic [wrp_pkg::LEN_W-1:0]         len_reg, len_next;

    logic [63:0]                       cnt64;
    logic [63:0]                       need;
    logic [63:0]                       end_addr;
    logic [wrp_pkg::LAST_W-1:0]        first_blk;
    logic [wrp_pkg::LAST_W-1:0]        diff;
    logic [63:0]                       phys;
    logic [63:0]                       avail;
    logic [63:0]                       contig;
    logic [63:0]                       clip;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= wrp_pkg::S_CLEAR;
            idx_reg    <= '0;
            left_reg   <= '0;
            wr_pos_reg <= '0;
            rd_pos_reg <= '0;
            cm_pos_reg <= '0;
        end else begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            left_reg   <= left_next;
            wr_pos_reg <= wr_pos_next;
            rd_pos_reg <= rd_pos_next;
            cm_pos_reg <= cm_pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        off_reg    <= off_next;
        cnt_reg    <= cnt_next;
        last_reg   <= last_next;
        status_reg <= status_next;
        pos_reg    <= pos_next;
        len_reg    <= len_next;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            wrp_pkg::S_CLEAR: begin
                if (idx_reg == wrp_pkg::IDX_LAST) begin
                    state_next = wrp_pkg::S_IDLE;
                end
            end
            wrp_pkg::S_IDLE: begin
                if (s_valid) begin
                    state_next = wrp_pkg::S_EXEC;
                end
            end
            wrp_pkg::S_EXEC: begin
                if (op_reg == wrp_pkg::OP_COMMIT) begin
                    if (cnt_reg == '0) begin
                        state_next = wrp_pkg::S_WALK_RD;
                    end else begin
                        state_next = wrp_pkg::S_SPAN;
                    end
                end else begin
                    state_next = wrp_pkg::S_DONE;
                end
            end
            wrp_pkg::S_SPAN: begin
                state_next = wrp_pkg::S_MARK;
            end
            wrp_pkg::S_MARK: begin
                if (left_reg == wrp_pkg::CNT_W'(1)) begin
                    state_next = wrp_pkg::S_WALK_RD;
                end
            end
            wrp_pkg::S_WALK_RD: begin
                if (cm_pos_reg >= wr_pos_reg) begin
                    state_next = wrp_pkg::S_DONE;
                end else begin
                    state_next = wrp_pkg::S_WALK_CHK;
                end
            end
            wrp_pkg::S_WALK_CHK: begin
                if (ram_rdata) begin
                    state_next = wrp_pkg::S_WALK_RD;
                end else begin
                    state_next = wrp_pkg::S_DONE;
                end
            end
            wrp_pkg::S_DONE: begin
                if (res_ready) begin
                    state_next = wrp_pkg::S_IDLE;
                end
            end
            default: state_next = wrp_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        cnt64     = 64'(cnt_reg);
        need      = wr_pos_reg + cnt64 - rd_pos_reg;
        end_addr  = off_reg + cnt64 - 64'(1);
        first_blk = off_reg[63:wrp_pkg::BLOCK_LOG2];
        diff      = last_reg - first_blk;
        phys      = rd_pos_reg & wrp_pkg::RING_MASK;
        avail     = cm_pos_reg - rd_pos_reg;
        contig    = wrp_pkg::RING_BYTES - phys;
        clip      = (avail > contig) ? contig : avail;
        if (clip > 64'(wrp_pkg::LEN_MAX)) begin
            clip = 64'(wrp_pkg::LEN_MAX);
        end
    end

    always_comb begin
        op_next     = op_reg;
        off_next    = off_reg;
        cnt_next    = cnt_reg;
        wr_pos_next = wr_pos_reg;
        rd_pos_next = rd_pos_reg;
        cm_pos_next = cm_pos_reg;
        idx_next    = idx_reg;
        left_next   = left_reg;
        last_next   = last_reg;
        status_next = status_reg;
        pos_next    = pos_reg;
        len_next    = len_reg;

        ram_req.we    = 1'b0;
        ram_req.waddr = idx_reg;
        ram_req.wdata = 1'b0;
        ram_req.raddr = cm_pos_reg[wrp_pkg::BLOCK_LOG2 +: wrp_pkg::IDX_W];

        s_ready   = (state_reg == wrp_pkg::S_IDLE);
        res_valid = (state_reg == wrp_pkg::S_DONE);
        res_data.status          = status_reg;
        res_data.position        = pos_reg;
        res_data.length          = len_reg;
        res_data.commit_position = cm_pos_reg;

        unique case (state_reg)
            wrp_pkg::S_CLEAR: begin
                ram_req.we = 1'b1;
                idx_next   = idx_reg + wrp_pkg::IDX_W'(1);
            end
            wrp_pkg::S_IDLE: begin
                if (s_valid) begin
                    op_next  = s_data.opcode;
                    off_next = s_data.range_base;
                    cnt_next = s_data.byte_count;
                end
            end
            wrp_pkg::S_EXEC: begin
                status_next = wrp_pkg::STAT_OK;
                pos_next    = '0;
                len_next    = '0;
                unique case (op_reg)
                    wrp_pkg::OP_RESERVE: begin
                        if (need > wrp_pkg::RING_BYTES) begin
                            status_next = wrp_pkg::STAT_NO_ROOM;
                        end else begin
                            pos_next    = wr_pos_reg;
                            wr_pos_next = wr_pos_reg + cnt64;
                        end
                    end
                    wrp_pkg::OP_COMMIT: begin
                        if (end_addr < off_reg) begin
                            last_next = '1;
                        end else begin
                            last_next = end_addr[63:wrp_pkg::BLOCK_LOG2];
                        end
                    end
                    wrp_pkg::OP_PEEK: begin
                        if (rd_pos_reg >= cm_pos_reg) begin
                            status_next = wrp_pkg::STAT_EMPTY;
                        end else begin
                            pos_next = phys;
                            len_next = clip[wrp_pkg::LEN_W-1:0];
                        end
                    end
                    wrp_pkg::OP_ADVANCE: begin
                        rd_pos_next = rd_pos_reg + cnt64;
                    end
                    default: begin
                        status_next = wrp_pkg::STAT_OK;
                    end
                endcase
            end
            wrp_pkg::S_SPAN: begin
                if (diff >= wrp_pkg::LAST_W'(wrp_pkg::NUM_BLOCKS - 1)) begin
                    idx_next  = '0;
                    left_next = wrp_pkg::CNT_W'(wrp_pkg::NUM_BLOCKS);
                end else begin
                    idx_next  = first_blk[wrp_pkg::IDX_W-1:0];
                    left_next = wrp_pkg::CNT_W'(diff[wrp_pkg::IDX_W-1:0])
                              + wrp_pkg::CNT_W'(1);
                end
            end
            wrp_pkg::S_MARK: begin
                ram_req.we    = 1'b1;
                ram_req.wdata = 1'b1;
                idx_next      = idx_reg + wrp_pkg::IDX_W'(1);
                left_next     = left_reg - wrp_pkg::CNT_W'(1);
            end
            wrp_pkg::S_WALK_RD: begin
                left_next = left_reg;
            end
            wrp_pkg::S_WALK_CHK: begin
                if (ram_rdata) begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = cm_pos_reg[wrp_pkg::BLOCK_LOG2 +: wrp_pkg::IDX_W];
                    cm_pos_next   = cm_pos_reg + wrp_pkg::BLK_BYTES;
                end
            end
            wrp_pkg::S_DONE: begin
                left_next = left_reg;
            end
            default: begin
                left_next = left_reg;
            end
        endcase
    end

endmodule

[src/wal_ring_pointer_manager.sv]
// Reserve, peek and advance pass S_EXEC and S_DONE to the output register; S_DONE waits
// while that is full and m_ready low. Commit passes S_EXEC, S_SPAN and S_MARK (N blocks
// marked one per cycle; both skipped for a zero byte count), then retires R blocks by a
// RAM read, then check and clear; a clear flag ends the walk. One item is in work at a time;
// s_ready returns in the cycle after the result moves to the output register. Synchronous
// reset zeroes all heads, then a pass clears all 16 flag RAM entries with s_ready low.
module wal_ring_pointer_manager (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  wrp_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output wrp_pkg::out_item_t m_data
);

    logic               res_valid;
    logic               res_ready;
    wrp_pkg::out_item_t res_data;
    wrp_pkg::ram_req_t  ram_req;
    logic               ram_rdata;

    logic               m_valid_reg, m_valid_next;
    wrp_pkg::out_item_t m_data_reg, m_data_next;

    wrp_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

    wrp_ram #(
        .WIDTH (1),
        .DEPTH (wrp_pkg::NUM_BLOCKS)
    ) u_flag_ram (
        .aclk  (aclk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
            m_data_next  = res_data;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
